// ===== src/spf_pkg.sv =====
// shared constants, types and the crc-16 byte update for the sample packet framer
// no dependencies; used by spf_crc16 and sample_packet_framer_crc16
package spf_pkg;

	localparam int unsigned GPP_W      = 5;
	localparam int unsigned COUNT_W    = GPP_W + 1;
	localparam int unsigned AXIS_W     = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CRC_W      = 16;
	localparam int unsigned PKT_NUM_W  = 8;
	localparam int unsigned SEQ_W      = 16;
	localparam int unsigned STEP_W     = 4;

	localparam logic [GPP_W-1:0]   GPP_RESET  = 5'd30;
	localparam logic [COUNT_W-1:0] GPP_ZERO_AS = 6'd32;
	localparam logic [CRC_W-1:0]   CRC_INIT   = 16'hFFFF;
	localparam logic [CRC_W-1:0]   CRC_POLY   = 16'hA001;

	typedef logic [STEP_W-1:0] step_t;

	// byte slots of one request, in send order
	localparam step_t STEP_ID         = 4'd0;
	localparam step_t STEP_DATA_FIRST = 4'd1;
	localparam step_t STEP_DATA_LAST  = 4'd8;
	localparam step_t STEP_CRC_HI     = 4'd9;
	localparam step_t STEP_CRC_LO     = 4'd10;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// controls for the running crc register
	typedef struct packed {
		logic absorb;   // fold data byte into the crc
		logic seed;     // start from the init value instead of the register
		logic clear;    // return the register to the init value
	} crc_ctrl_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/spf_if.sv =====
// valid/ready channel interfaces for sample requests and framed bytes
// depends on nothing; used by sample_packet_framer_crc16
interface spf_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;

	modport source (output valid, output operation, output axis_x, output axis_y,
		output axis_z, input ready);
	modport sink (input valid, input operation, input axis_x, input axis_y,
		input axis_z, output ready);
endinterface

interface spf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_packet;
	logic       end_of_run;

	modport source (output valid, output out_byte, output end_of_packet,
		output end_of_run, input ready);
	modport sink (input valid, input out_byte, input end_of_packet,
		input end_of_run, output ready);
endinterface

// ===== src/sample_packet_framer_crc16.sv =====
// top level of the sample packet framer: request buffer, byte sequencer, output register
// depends on spf_pkg, spf_in_if / spf_out_if and spf_crc16
//
//   channel      dir  payload                                        handshake
//   sample_in    in   operation, axis_x, axis_y, axis_z              valid / ready
//   frame_out    out  out_byte, end_of_packet, end_of_run            valid / ready
//   cfg          in   cfg_wdata = group limit (5 bits)               cfg_we, no wait
//
// the byte-wide output register sends one byte per cycle while frame_out is ready: a sample request
// sends 8 bytes, 9 if it opens a packet, 10 if it closes one, 11 for both; a flush sends 2, none if empty
// the next request is taken in the cycle the current one issues its last byte
// arst_n clears all control state, the crc to 0xFFFF and the group limit to 30
// a stall on frame_out holds the output register and freezes the sequencer, but an empty flush still completes
module sample_packet_framer_crc16 #(
	parameter logic [spf_pkg::GPP_W-1:0] GppReset = spf_pkg::GPP_RESET
) (
	input  logic                        clk,
	input  logic                        arst_n,
	spf_in_if.sink                      sample_in,
	spf_out_if.source                   frame_out,
	input  logic                        cfg_we,
	input  logic [spf_pkg::GPP_W-1:0]   cfg_wdata
);

	// request buffer
	logic                               item_v_s1;
	logic                               op_s1;
	logic [spf_pkg::AXIS_W-1:0]         x_s1;
	logic [spf_pkg::AXIS_W-1:0]         y_s1;
	logic [spf_pkg::AXIS_W-1:0]         z_s1;

	// sequencer position within the current request
	logic                               started_q;
	spf_pkg::step_t                     step_q;

	// framing state
	logic [spf_pkg::GPP_W-1:0]          gpp_q;
	logic [spf_pkg::PKT_NUM_W-1:0]      pkt_num_q;
	logic [spf_pkg::GPP_W-1:0]          groups_q;
	logic [spf_pkg::SEQ_W-1:0]          seq_q;
	logic                               open_q;

	// output register
	logic                               out_v_q;
	logic [spf_pkg::BYTE_W-1:0]         byte_q;
	logic                               eop_q;
	logic                               eor_q;

	logic [spf_pkg::COUNT_W-1:0]        limit;
	logic [spf_pkg::COUNT_W-1:0]        count;
	logic                               close_now;
	logic                               closes;
	spf_pkg::step_t                     first_step;
	spf_pkg::step_t                     cur_step;
	spf_pkg::step_t                     last_step;
	spf_pkg::step_t                     data_idx;
	logic                               empty_flush;
	logic                               out_free;
	logic                               fire;
	logic                               emit;
	logic                               done;
	logic                               is_last;
	logic [spf_pkg::PKT_NUM_W-1:0]      pkt_next;
	logic [spf_pkg::AXIS_W-1:0]         word;
	logic [spf_pkg::BYTE_W-1:0]         byte_d;
	logic [spf_pkg::CRC_W-1:0]          crc;
	spf_pkg::crc_ctrl_t                 crc_ctrl;

	// a group limit of zero counts as 32
	assign limit     = (gpp_q == '0) ? spf_pkg::GPP_ZERO_AS : {1'b0, gpp_q};
	assign count     = {1'b0, groups_q} + {{(spf_pkg::COUNT_W-1){1'b0}}, 1'b1};
	assign close_now = (count >= limit);
	assign closes    = (op_s1 == spf_pkg::OP_FLUSH) || close_now;
	assign pkt_next  = pkt_num_q + {{(spf_pkg::PKT_NUM_W-1){1'b0}}, 1'b1};

	// where the request starts and ends in the byte slot list
	assign first_step = (op_s1 == spf_pkg::OP_FLUSH) ? spf_pkg::STEP_CRC_HI :
		(open_q ? spf_pkg::STEP_DATA_FIRST : spf_pkg::STEP_ID);
	assign cur_step   = started_q ? step_q : first_step;
	assign last_step  = closes ? spf_pkg::STEP_CRC_LO : spf_pkg::STEP_DATA_LAST;
	assign is_last    = (cur_step == last_step);

	// flush on an empty packet sends nothing, only bumps the packet id
	assign empty_flush = (op_s1 == spf_pkg::OP_FLUSH) && !open_q && !started_q;
	assign out_free    = !out_v_q || frame_out.ready;
	assign fire        = item_v_s1 && (empty_flush || out_free);
	assign emit        = fire && !empty_flush;
	assign done        = fire && (empty_flush || is_last);

	assign sample_in.ready = !item_v_s1 || done;

	// data slots: sequence, x, y, z, each high byte first
	assign data_idx = cur_step - spf_pkg::STEP_DATA_FIRST;

	always_comb begin
		unique case (data_idx[2:1])
			2'd0:    word = seq_q;
			2'd1:    word = x_s1;
			2'd2:    word = y_s1;
			default: word = z_s1;
		endcase
	end

	always_comb begin
		unique case (cur_step)
			spf_pkg::STEP_ID:     byte_d = pkt_next;
			spf_pkg::STEP_CRC_HI: byte_d = crc[15:8];
			spf_pkg::STEP_CRC_LO: byte_d = crc[7:0];
			default:              byte_d = data_idx[0] ? word[7:0] : word[15:8];
		endcase
	end

	// id byte restarts the crc, data bytes fold in, the low crc byte clears it
	always_comb begin
		crc_ctrl.seed   = (cur_step == spf_pkg::STEP_ID);
		crc_ctrl.absorb = emit && (cur_step <= spf_pkg::STEP_DATA_LAST);
		crc_ctrl.clear  = emit && (cur_step == spf_pkg::STEP_CRC_LO);
	end

	spf_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (byte_d),
		.crc    (crc)
	);

	// request buffer: payload needs no reset
	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			op_s1 <= sample_in.operation;
			x_s1  <= sample_in.axis_x;
			y_s1  <= sample_in.axis_y;
			z_s1  <= sample_in.axis_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			item_v_s1 <= sample_in.valid;
		end
	end

	// sequencer and framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			step_q    <= spf_pkg::STEP_ID;
			gpp_q     <= GppReset;
			pkt_num_q <= '0;
			groups_q  <= '0;
			seq_q     <= '0;
			open_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				gpp_q <= cfg_wdata;
			end
			if (done) begin
				started_q <= 1'b0;
			end else if (emit) begin
				started_q <= 1'b1;
				step_q    <= cur_step + spf_pkg::STEP_DATA_FIRST;
			end
			// packet id advances as its byte goes out, or on an empty flush
			if ((emit && cur_step == spf_pkg::STEP_ID) || (fire && empty_flush)) begin
				pkt_num_q <= pkt_next;
			end
			if (done && !empty_flush) begin
				if (op_s1 == spf_pkg::OP_SAMPLE) begin
					seq_q <= seq_q + {{(spf_pkg::SEQ_W-1){1'b0}}, 1'b1};
				end
				groups_q <= closes ? '0 : count[spf_pkg::GPP_W-1:0];
				open_q   <= !closes;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_d;
			eop_q  <= (cur_step == spf_pkg::STEP_CRC_LO);
			eor_q  <= is_last;
		end
	end

	assign frame_out.valid         = out_v_q;
	assign frame_out.out_byte      = byte_q;
	assign frame_out.end_of_packet = eop_q;
	assign frame_out.end_of_run    = eor_q;

endmodule

// ===== src/spf_crc16.sv =====
// running crc-16 register (reflected poly 0xA001, init 0xFFFF), one byte per cycle
// depends on spf_pkg
module spf_crc16 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spf_pkg::crc_ctrl_t            ctrl,
	input  logic [spf_pkg::BYTE_W-1:0]    data,
	output logic [spf_pkg::CRC_W-1:0]     crc
);

	logic [spf_pkg::CRC_W-1:0] crc_q;
	logic [spf_pkg::CRC_W-1:0] base;

	assign base = ctrl.seed ? spf_pkg::CRC_INIT : crc_q;
	assign crc  = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= spf_pkg::CRC_INIT;
		end else if (ctrl.clear) begin
			crc_q <= spf_pkg::CRC_INIT;
		end else if (ctrl.absorb) begin
			crc_q <= spf_pkg::crc_byte(base, data);
		end
	end

endmodule

// ===== tb/sv/tb_sample_packet_framer_crc16.sv =====
`timescale 1ns / 1ps
// self-checking testbench for sample_packet_framer_crc16: directed and random sample requests
// depends on spf_pkg, spf_in_if / spf_out_if and the framer rtl
module tb_sample_packet_framer_crc16;

	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 16;       // covers a flush on an empty packet still in flight
	localparam int HOLD_LEN      = 300;      // long receiver hold-off for the pressure phase
	localparam int LIMIT_CYCLES  = 200000;   // many times what a clean run with stalls needs
	localparam int MAX_REPORTS   = 10;

	// one sample request as offered on sample_in
	typedef struct packed {
		logic        op;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} sample_req_t;

	// one framed byte as expected on frame_out
	typedef struct packed {
		logic [7:0] data;
		logic       eop;
		logic       eor;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// testbench-side drive registers, all known from time zero
	logic        req_valid = 1'b0;
	logic        req_op = spf_pkg::OP_SAMPLE;
	logic [15:0] req_x = '0;
	logic [15:0] req_y = '0;
	logic [15:0] req_z = '0;
	logic        take_ready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [spf_pkg::GPP_W-1:0] cfg_wdata = '0;

	spf_in_if  sample_if ();
	spf_out_if frame_if ();

	assign sample_if.valid     = req_valid;
	assign sample_if.operation = req_op;
	assign sample_if.axis_x    = req_x;
	assign sample_if.axis_y    = req_y;
	assign sample_if.axis_z    = req_z;
	assign frame_if.ready      = take_ready;

	sample_packet_framer_crc16 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_if),
		.frame_out (frame_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// stimulus and flow control shared between processes
	sample_req_t req_queue [$];   // requests not yet offered
	sample_req_t offered;         // request currently on sample_in
	frame_byte_t bytes_due [$];   // framed bytes still to arrive, oldest first
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	// framer mirror: register, packet state, crc
	logic [spf_pkg::GPP_W-1:0] group_limit = spf_pkg::GPP_RESET;
	logic [spf_pkg::CRC_W-1:0] crc_acc = spf_pkg::CRC_INIT;
	logic [7:0]       pkt_id = '0;
	logic [spf_pkg::GPP_W-1:0] groups_held = '0;
	logic [15:0]      seq_no = '0;
	logic             pkt_open = 1'b0;

	// bytes produced by the request being framed
	logic [7:0] stage_data [0:10];
	logic       stage_eop [0:10];
	int         stage_n;

	// run statistics
	int errors = 0;
	int n_samples = 0;
	int n_flushes = 0;
	int n_bytes = 0;
	int n_packets = 0;
	int n_cfg = 0;
	int pkt_wraps = 0;
	int seq_wraps = 0;

	// crc-16 fold of one byte, lsb first, reflected 0xA001
	function automatic logic [spf_pkg::CRC_W-1:0] crc16_fold(
		input logic [spf_pkg::CRC_W-1:0] crc, input logic [7:0] b);
		logic [spf_pkg::CRC_W-1:0] r;
		logic             fb;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ b[k];
			r = r >> 1;
			if (fb) begin
				r = r ^ spf_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic void stage_byte(input logic [7:0] b, input logic eop, input logic fold);
		if (fold) begin
			crc_acc = crc16_fold(crc_acc, b);
		end
		stage_data[stage_n] = b;
		stage_eop[stage_n] = eop;
		stage_n++;
	endfunction

	// big-endian data word, both bytes go into the crc
	function automatic void stage_word(input logic [15:0] w);
		stage_byte(w[15:8], 1'b0, 1'b1);
		stage_byte(w[7:0], 1'b0, 1'b1);
	endfunction

	// crc high byte then low byte, the low byte ends the packet
	function automatic void stage_close();
		stage_byte(crc_acc[15:8], 1'b0, 1'b0);
		stage_byte(crc_acc[7:0], 1'b1, 1'b0);
		pkt_open = 1'b0;
		groups_held = '0;
		crc_acc = spf_pkg::CRC_INIT;
	endfunction

	function automatic void next_packet_id();
		pkt_id = pkt_id + 8'd1;
		if (pkt_id == '0) begin
			pkt_wraps++;
		end
	endfunction

	// frame one accepted request and queue the bytes it must produce
	task automatic frame_request(input sample_req_t r);
		int limit;
		int i;
		stage_n = 0;
		if (r.op == spf_pkg::OP_SAMPLE) begin
			n_samples++;
			// a limit of zero means 32 groups
			limit = (group_limit == '0) ? 32 : int'(group_limit);
			if (!pkt_open) begin
				// new packet: id advances first, crc restarts over the id
				next_packet_id();
				crc_acc = spf_pkg::CRC_INIT;
				stage_byte(pkt_id, 1'b0, 1'b1);
				pkt_open = 1'b1;
				groups_held = '0;
			end
			stage_word(seq_no);
			seq_no = seq_no + 16'd1;
			if (seq_no == '0) begin
				seq_wraps++;
			end
			stage_word(r.x);
			stage_word(r.y);
			stage_word(r.z);
			// closes at or above the limit, also after the limit was lowered
			if (int'(groups_held) + 1 >= limit) begin
				stage_close();
			end else begin
				groups_held = groups_held + 1'b1;
			end
		end else begin
			n_flushes++;
			if (pkt_open) begin
				stage_close();
			end else begin
				// empty flush only burns an id
				next_packet_id();
			end
		end
		for (i = 0; i < stage_n; i++) begin
			bytes_due.push_back({stage_data[i], stage_eop[i], (i == stage_n - 1) ? 1'b1 : 1'b0});
		end
	endtask

	task automatic flag_error(input string what, input frame_byte_t want, input frame_byte_t got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("mismatch at byte %0d (%s): expected %02h eop %0b eor %0b, got %02h eop %0b eor %0b",
				n_bytes, what, want.data, want.eop, want.eor, got.data, got.eop, got.eor);
		end
	endtask

	// driver: offers queued requests, predicts each one as it is taken
	always @(posedge clk) begin
		if (sample_if.valid && sample_if.ready) begin
			frame_request(offered);
		end
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!sample_if.valid || sample_if.ready) begin
			// slot is free: offer the next request unless this cycle idles
			if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				offered = req_queue.pop_front();
				req_valid <= 1'b1;
				req_op <= offered.op;
				req_x <= offered.x;
				req_y <= offered.y;
				req_z <= offered.z;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver hold-off, counted here so the driver keeps pushing meanwhile
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
		end
	end

	// monitor: checks every taken byte against the oldest expectation
	always @(posedge clk) begin
		frame_byte_t want;
		frame_byte_t got;
		if (frame_if.valid && frame_if.ready) begin
			got = {frame_if.out_byte, frame_if.end_of_packet, frame_if.end_of_run};
			if (bytes_due.size() == 0) begin
				flag_error("nothing pending", '0, got);
			end else begin
				want = bytes_due.pop_front();
				if (got.data !== want.data || got.eop !== want.eop || got.eor !== want.eor) begin
					flag_error("field differs", want, got);
				end else if (got.eop) begin
					n_packets++;
				end
			end
			n_bytes++;
		end
		take_ready <= arst_n && hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_sample_packet_framer_crc16: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] random_axis();
		// extremes show up often enough to hit every corner
		unique case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic queue_req(input logic op, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z);
		req_queue.push_back({op, x, y, z});
	endtask

	task automatic queue_random(input int count, input int flush_pct);
		repeat (count) begin
			queue_req(($urandom_range(0, 99) < flush_pct) ? spf_pkg::OP_FLUSH : spf_pkg::OP_SAMPLE,
				random_axis(), random_axis(), random_axis());
		end
	endtask

	// wait until every request is taken and every byte has come out, plus a margin
	task automatic drain();
		do begin
			@(negedge clk);
		end while (req_queue.size() != 0 || sample_if.valid || bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write while the framer is idle
	task automatic write_group_limit(input logic [spf_pkg::GPP_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		group_limit = value;
		n_cfg++;
		@(negedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: slow sender, very slow receiver
		send_idle_pct = 23;
		recv_idle_pct = 88;
		// flush on empty packet, then extremes under the reset limit of 30
		queue_req(spf_pkg::OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		queue_req(spf_pkg::OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000);
		queue_req(spf_pkg::OP_SAMPLE, 16'hFFFF, 16'h0001, 16'h7FFF);
		// flush of an open packet, then another on the now empty one
		queue_req(spf_pkg::OP_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_req(spf_pkg::OP_FLUSH, 16'h8000, 16'h8000, 16'h8000);
		// one group per packet: id, data and crc in one request
		write_group_limit(5'd1);
		queue_req(spf_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFFF);
		queue_req(spf_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		queue_req(spf_pkg::OP_FLUSH, 16'h5555, 16'hAAAA, 16'h5555);
		// leave a packet open at the top limit, then lower the limit under it
		write_group_limit(5'd31);
		queue_req(spf_pkg::OP_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA);
		queue_req(spf_pkg::OP_SAMPLE, 16'h1234, 16'hFEDC, 16'h00FF);
		queue_req(spf_pkg::OP_SAMPLE, 16'hFF00, 16'h0F0F, 16'hF0F0);
		write_group_limit(5'd2);
		queue_req(spf_pkg::OP_SAMPLE, 16'h0001, 16'h8001, 16'h7FFE);
		// zero limit stands for 32 groups
		write_group_limit(5'd0);
		queue_req(spf_pkg::OP_SAMPLE, 16'hC000, 16'h3FFF, 16'h8000);
		queue_req(spf_pkg::OP_SAMPLE, 16'h7FFF, 16'hFFFF, 16'h0000);
		queue_req(spf_pkg::OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);

		// random, sender mostly busy and receiver mostly stalled
		write_group_limit(5'd3);
		queue_random(30, 12);
		write_group_limit(5'($urandom_range(1, 31)));
		queue_random(30, 12);

		// random, the other way round
		send_idle_pct = 88;
		recv_idle_pct = 23;
		write_group_limit(5'd31);
		queue_random(30, 8);
		write_group_limit(5'd5);
		queue_random(30, 15);

		// pressure: receiver holds off while the sender keeps offering full packets
		write_group_limit(5'd1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = ~hold_req;
		queue_random(24, 0);

		// random with no idling on either side
		write_group_limit(5'($urandom_range(2, 30)));
		queue_random(25, 12);
		write_group_limit(5'd0);
		queue_random(25, 5);

		drain();
		$display("covered %0d samples and %0d flushes over %0d limit writes, extremes included",
			n_samples, n_flushes, n_cfg);
		$display("checked %0d bytes in %0d packets; id wrapped %0d time(s), sequence %0d time(s)",
			n_bytes, n_packets, pkt_wraps, seq_wraps);
		if (errors == 0 && bytes_due.size() == 0) begin
			$display("tb_sample_packet_framer_crc16: done, clean");
		end else begin
			$display("tb_sample_packet_framer_crc16: done, errors");
		end
		$finish;
	end

endmodule

// ===== sample_packet_framer_crc16.f =====
src/spf_pkg.sv
src/spf_if.sv
src/spf_crc16.sv
src/sample_packet_framer_crc16.sv
tb/sv/tb_sample_packet_framer_crc16.sv
